@@ hw/rtl/nbc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the naive Bayes classifier unit.
// No dependencies.
package nbc_pkg;

  localparam int DIGIT_BITS = 32;

  typedef enum logic [1:0] {
    OP_TRAIN    = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_NONE     = 2'd3
  } nbc_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TR_RD,
    S_TR_CHK,
    S_TR_WRD,
    S_TR_WR,
    S_CL_INIT,
    S_CL_RD,
    S_CL_M1,
    S_CL_W1,
    S_CL_M2,
    S_CL_W2,
    S_CMP,
    S_CMP_W,
    S_DONE
  } nbc_state_t;

  // Commands from the sequencer to the serial multiplier.
  typedef struct packed {
    logic load;  // set accumulator of side sel to init value
    logic mul;   // multiply accumulator of side sel by factor
    logic cmp;   // compare side 0 against side 1
    logic sel;
  } nbc_ctl_t;

endpackage

@@ hw/rtl/nbc_count_store.sv @@
`timescale 1ns / 1ps
// Count memory with per-entry valid bits; unwritten entries read as zero.
// Depends on nothing outside this file.
module nbc_count_store #(
  parameter int DEPTH = 96,
  parameter int CB    = 10,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [CB-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [CB-1:0] wr_data
);

  logic [CB-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [CB-1:0]    rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

@@ hw/rtl/nbc_serial_mul.sv @@
`timescale 1ns / 1ps
// Digit-serial wide accumulators for the two class scores: multiply by a
// narrow factor one digit per cycle, and compare LSB-first. Uses nbc_pkg.
module nbc_serial_mul #(
  parameter int CB = 10,
  parameter int FB = 12,
  parameter int ND = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  nbc_pkg::nbc_ctl_t ctl,
  input  logic [CB-1:0]    init_val,
  input  logic [FB-1:0]    factor,
  output logic             busy,
  output logic             gt
);
  import nbc_pkg::*;

  localparam int DW = DIGIT_BITS;
  localparam int CW = (ND > 1) ? $clog2(ND) : 1;

  logic [DW-1:0]    acc0_r [ND];
  logic [DW-1:0]    acc1_r [ND];
  logic             run_r;
  logic             cmp_r;
  logic             sel_r;
  logic [CW-1:0]    cnt_r;
  logic [FB-1:0]    fac_r;
  logic [FB-1:0]    carry_r;
  logic             gt_r;
  logic [DW-1:0]    digit;
  logic [DW+FB-1:0] prod;
  logic             last;

  assign digit = sel_r ? acc1_r[0] : acc0_r[0];
  assign prod  = (DW+FB)'(digit) * (DW+FB)'(fac_r) + (DW+FB)'(carry_r);
  assign last  = (cnt_r == CW'(ND - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (ctl.mul || ctl.cmp) begin
      run_r <= 1'b1;
    end else if (run_r && last) begin
      run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < ND; i++) begin
        if (ctl.sel) begin
          acc1_r[i] <= (i == 0) ? DW'(init_val) : '0;
        end else begin
          acc0_r[i] <= (i == 0) ? DW'(init_val) : '0;
        end
      end
    end else if (ctl.mul || ctl.cmp) begin
      cmp_r   <= ctl.cmp;
      sel_r   <= ctl.sel;
      fac_r   <= factor;
      carry_r <= '0;
      cnt_r   <= '0;
      if (ctl.cmp) begin
        gt_r <= 1'b0;
      end
    end else if (run_r) begin
      cnt_r <= cnt_r + CW'(1);
      if (cmp_r) begin
        // later digits are more significant and override
        if (acc0_r[0] > acc1_r[0]) begin
          gt_r <= 1'b1;
        end else if (acc0_r[0] < acc1_r[0]) begin
          gt_r <= 1'b0;
        end
        for (int i = 0; i < ND - 1; i++) begin
          acc0_r[i] <= acc0_r[i+1];
          acc1_r[i] <= acc1_r[i+1];
        end
        acc0_r[ND-1] <= acc0_r[0];
        acc1_r[ND-1] <= acc1_r[0];
      end else begin
        carry_r <= prod[DW +: FB];
        for (int i = 0; i < ND - 1; i++) begin
          if (sel_r) begin
            acc1_r[i] <= acc1_r[i+1];
          end else begin
            acc0_r[i] <= acc0_r[i+1];
          end
        end
        if (sel_r) begin
          acc1_r[ND-1] <= prod[DW-1:0];
        end else begin
          acc0_r[ND-1] <= prod[DW-1:0];
        end
      end
    end
  end

  assign busy = run_r;
  assign gt   = gt_r;

endmodule

@@ hw/rtl/naive_bayes_categorical_classifier_unit.sv @@
`timescale 1ns / 1ps
// Two-class naive Bayes classifier, exact decision by cross-multiplication.
// A classify compares the two class scores, kept as ND 32-bit digits (12 at
// defaults) in the digit-serial score multiplier. A train reads all counts
// of the item first and writes them only if none is saturated, else drops
// the item. Clear and op 3 only return a result.
// One item at a time. Reset (rst_n, synchronous) or clear zeroes all counts.
module naive_bayes_categorical_classifier_unit #(
  parameter int NUM_FEATURES = 16,
  parameter int COUNT_BITS   = 10,
  parameter int NUM_VALUES   = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // label [0], feature_vector [32:1], zero pad
  input  logic [1:0]  in_tuser,   // op [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // predicted_class [0], zero pad
  output logic [0:0]  out_tuser   // dropped [0]
);
  import nbc_pkg::*;

  localparam int CB    = COUNT_BITS;
  localparam int FB    = COUNT_BITS + 2;
  localparam int W     = COUNT_BITS + 2 * NUM_FEATURES * (COUNT_BITS + 1);
  localparam int ND    = (W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int DEPTH = 2 * NUM_FEATURES * NUM_VALUES;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam logic [AW-1:0] CLS1_BASE = AW'(NUM_FEATURES * NUM_VALUES);
  localparam logic [CB-1:0] CNT_MAX   = {CB{1'b1}};

  nbc_state_t    state_r, state_nxt;
  logic          out_valid_r;
  logic          pred_r, drop_out_r;
  logic [CB-1:0] cls_cnt_r [2];
  logic [1:0]    op_r;
  logic          label_r;
  logic [31:0]   fv_r, fv_sh_r;
  logic [FW-1:0] fidx_r;
  logic [AW-1:0] base_r;
  logic          full_r;
  logic          drop_r;
  logic          cls_r;

  logic          in_fire, can_load, f_last, v_ok, entry_full, full_now;
  logic [1:0]    v;
  logic [AW-1:0] addr;
  logic [CB-1:0] rd_data;
  logic          rd_en, wr_en, st_clear;
  nbc_ctl_t      ctl;
  logic [CB-1:0] init_val;
  logic [FB-1:0] factor;
  logic          eng_busy, eng_gt;

  assign in_fire    = in_tvalid && in_tready;
  assign can_load   = !out_valid_r || out_tready;
  assign f_last     = (fidx_r == FW'(NUM_FEATURES - 1));
  assign v          = fv_sh_r[1:0];
  assign v_ok       = ({1'b0, v} < 3'(NUM_VALUES));
  assign addr       = base_r + AW'(v);
  assign entry_full = v_ok && (rd_data == CNT_MAX);
  assign full_now   = full_r || entry_full || (cls_cnt_r[label_r] == CNT_MAX);

  nbc_count_store #(.DEPTH(DEPTH), .CB(CB), .AW(AW)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (st_clear),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (rd_data + CB'(1))
  );

  nbc_serial_mul #(.CB(CB), .FB(FB), .ND(ND)) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .init_val (init_val),
    .factor   (factor),
    .busy     (eng_busy),
    .gt       (eng_gt)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            OP_TRAIN:    state_nxt = S_TR_RD;
            OP_CLASSIFY: state_nxt = S_CL_INIT;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_TR_RD:   state_nxt = S_TR_CHK;
      S_TR_CHK: begin
        if (f_last) begin
          state_nxt = full_now ? S_DONE : S_TR_WRD;
        end else begin
          state_nxt = S_TR_RD;
        end
      end
      S_TR_WRD:  state_nxt = S_TR_WR;
      S_TR_WR:   state_nxt = f_last ? S_DONE : S_TR_WRD;
      S_CL_INIT: state_nxt = S_CL_RD;
      S_CL_RD:   state_nxt = S_CL_M1;
      S_CL_M1:   state_nxt = S_CL_W1;
      S_CL_W1:   state_nxt = eng_busy ? S_CL_W1 : S_CL_M2;
      S_CL_M2:   state_nxt = S_CL_W2;
      S_CL_W2: begin
        if (!eng_busy) begin
          if (!f_last) begin
            state_nxt = S_CL_RD;
          end else begin
            state_nxt = cls_r ? S_CMP : S_CL_INIT;
          end
        end
      end
      S_CMP:     state_nxt = S_CMP_W;
      S_CMP_W:   state_nxt = eng_busy ? S_CMP_W : S_DONE;
      S_DONE:    state_nxt = can_load ? S_IDLE : S_DONE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    st_clear  = 1'b0;
    ctl       = '0;
    ctl.sel   = cls_r;
    init_val  = cls_cnt_r[cls_r];
    factor    = FB'({cls_cnt_r[!cls_r], 1'b0}) + FB'(2);
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        st_clear  = in_fire && (in_tuser == OP_CLEAR);
      end
      // skip the read for a value that is never counted
      S_TR_RD, S_TR_WRD, S_CL_RD: rd_en = v_ok;
      S_TR_WR:   wr_en    = v_ok;
      S_CL_INIT: ctl.load = 1'b1;
      S_CL_M1: begin
        ctl.mul = 1'b1;
        factor  = FB'({(v_ok ? rd_data : CB'(0)), 1'b1});
      end
      S_CL_M2:   ctl.mul  = 1'b1;
      S_CMP:     ctl.cmp  = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      cls_cnt_r[0] <= '0;
      cls_cnt_r[1] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (st_clear) begin
        cls_cnt_r[0] <= '0;
        cls_cnt_r[1] <= '0;
      end else if (state_r == S_TR_CHK && f_last && !full_now) begin
        cls_cnt_r[label_r] <= cls_cnt_r[label_r] + CB'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_r    <= in_tuser;
          label_r <= in_tdata[0];
          fv_r    <= in_tdata[32:1];
          fv_sh_r <= in_tdata[32:1];
          fidx_r  <= '0;
          base_r  <= in_tdata[0] ? CLS1_BASE : '0;
          full_r  <= 1'b0;
          drop_r  <= 1'b0;
          cls_r   <= 1'b0;
        end
      end
      S_TR_CHK: begin
        if (entry_full) begin
          full_r <= 1'b1;
        end
        if (f_last) begin
          drop_r  <= full_now;
          fidx_r  <= '0;
          base_r  <= label_r ? CLS1_BASE : '0;
          fv_sh_r <= fv_r;
        end else begin
          fidx_r  <= fidx_r + FW'(1);
          base_r  <= base_r + AW'(NUM_VALUES);
          fv_sh_r <= {2'b00, fv_sh_r[31:2]};
        end
      end
      S_TR_WR: begin
        fidx_r  <= fidx_r + FW'(1);
        base_r  <= base_r + AW'(NUM_VALUES);
        fv_sh_r <= {2'b00, fv_sh_r[31:2]};
      end
      S_CL_INIT: begin
        fidx_r  <= '0;
        base_r  <= cls_r ? CLS1_BASE : '0;
        fv_sh_r <= fv_r;
      end
      S_CL_W2: begin
        if (!eng_busy) begin
          fidx_r  <= fidx_r + FW'(1);
          base_r  <= base_r + AW'(NUM_VALUES);
          fv_sh_r <= {2'b00, fv_sh_r[31:2]};
          if (f_last) begin
            cls_r <= 1'b1;
          end
        end
      end
      S_DONE: begin
        if (can_load) begin
          pred_r     <= (op_r == OP_CLASSIFY) ? !eng_gt : 1'b0;
          drop_out_r <= (op_r == OP_TRAIN) ? drop_r : 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, pred_r};
  assign out_tuser  = drop_out_r;

  a_excl_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tuser[0]))
    else $error("class and drop flag both set");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.mul || ctl.cmp) |-> !eng_busy)
    else $error("multiplier started while busy");

  a_no_write_drop: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !drop_r)
    else $error("count written for a dropped item");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second item taken while busy");

endmodule
